// ===== rtl/csu_pkg.sv =====
package csu_pkg;

  localparam int ELEM_W      = 16;
  localparam int ACC_W       = 44;
  localparam int PROD_W      = 2 * ACC_W;
  localparam int QUO_W       = 32;
  localparam int ROOT_W      = QUO_W / 2;
  localparam int COS_W       = 17;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;
  localparam int COUNT_BITS  = 16;
  localparam int CNT_W       = $clog2(ACC_W);

  localparam logic [COS_W-1:0] Q_ONE = COS_W'(65536);

  localparam int MUL_STEPS  = ACC_W;
  localparam int DIV_STEPS  = QUO_W;
  localparam int SQRT_STEPS = ROOT_W;

  typedef struct packed {
    logic acc_en;
    logic load;
    logic mul_step;
    logic div_init;
    logic div_step;
    logic sqrt_step;
    logic out_load;
  } csu_cmd_t;

endpackage

// ===== rtl/csu_ctrl.sv =====
module csu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_tlast,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output csu_pkg::csu_cmd_t cmd
);
  import csu_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DINIT = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SQRT  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign accept     = in_tvalid && in_tready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    cmd.acc_en    = accept;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_tlast) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MUL_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DINIT;
        end
      end
      S_DINIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        cnt_nxt       = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQRT_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // wait for the output register to drain
        if (!out_valid_r) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/csu_dp.sv =====
module csu_dp #(
  parameter int COUNT_BITS = csu_pkg::COUNT_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  csu_pkg::csu_cmd_t         cmd,
  input  logic [csu_pkg::ELEM_W-1:0] elem_a,
  input  logic [csu_pkg::ELEM_W-1:0] elem_b,
  output logic [csu_pkg::COS_W-1:0]  cosine_q16,
  output logic                      degenerate
);
  import csu_pkg::*;

  localparam logic [ELEM_W-1:0] ELEM_LIM = (COUNT_BITS >= ELEM_W) ? {ELEM_W{1'b1}} :
                                           ELEM_W'((64'd1 << COUNT_BITS) - 64'd1);

  logic [ELEM_W-1:0]   a_s, b_s;
  logic [2*ELEM_W-1:0] p_ab, p_aa, p_bb;
  logic [ACC_W-1:0]    dot_sum, ma_sum, mb_sum;
  logic [ACC_W-1:0]    acc_dot_r, acc_ma_r, acc_mb_r;

  logic [PROD_W-1:0]   mcp_r, prod_r, mcd_r, dsq_r;
  logic [ACC_W-1:0]    mbp_r, mdd_r;
  logic [PROD_W:0]     rem_d_r, rem_sh;
  logic [QUO_W-1:0]    q_r;
  logic                clamp_r, degen_r;
  logic [ROOT_W-1:0]   root_r;
  logic [ROOT_W+1:0]   sq_rem_r;
  logic [ROOT_W+3:0]   sq_in, sq_trial;
  logic [COS_W-1:0]    cos_r;
  logic                degen_out_r;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                               input logic [2*ELEM_W-1:0] inc);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + (ACC_W + 1)'(inc);
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

  assign a_s  = (elem_a > ELEM_LIM) ? ELEM_LIM : elem_a;
  assign b_s  = (elem_b > ELEM_LIM) ? ELEM_LIM : elem_b;
  assign p_ab = a_s * b_s;
  assign p_aa = a_s * a_s;
  assign p_bb = b_s * b_s;

  assign dot_sum = sat_add(acc_dot_r, p_ab);
  assign ma_sum  = sat_add(acc_ma_r, p_aa);
  assign mb_sum  = sat_add(acc_mb_r, p_bb);

  assign rem_sh   = {rem_d_r[PROD_W-1:0], 1'b0};
  assign sq_in    = {sq_rem_r, q_r[QUO_W-1 -: 2]};
  assign sq_trial = (ROOT_W + 4)'({root_r, 2'b01});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_dot_r <= '0;
      acc_ma_r  <= '0;
      acc_mb_r  <= '0;
    end else if (cmd.load) begin
      acc_dot_r <= '0;
      acc_ma_r  <= '0;
      acc_mb_r  <= '0;
    end else if (cmd.acc_en) begin
      acc_dot_r <= dot_sum;
      acc_ma_r  <= ma_sum;
      acc_mb_r  <= mb_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // ma*mb and dot*dot by shift and add
      mcp_r    <= PROD_W'(ma_sum);
      mbp_r    <= mb_sum;
      prod_r   <= '0;
      mcd_r    <= PROD_W'(dot_sum);
      mdd_r    <= dot_sum;
      dsq_r    <= '0;
      degen_r  <= (ma_sum == '0) || (mb_sum == '0);
      root_r   <= '0;
      sq_rem_r <= '0;
    end
    if (cmd.mul_step) begin
      prod_r <= prod_r + (mbp_r[0] ? mcp_r : '0);
      mcp_r  <= mcp_r << 1;
      mbp_r  <= mbp_r >> 1;
      dsq_r  <= dsq_r + (mdd_r[0] ? mcd_r : '0);
      mcd_r  <= mcd_r << 1;
      mdd_r  <= mdd_r >> 1;
    end
    if (cmd.div_init) begin
      // dot^2 >= ma*mb means a cosine of one or more
      rem_d_r <= {1'b0, dsq_r};
      clamp_r <= (dsq_r >= prod_r);
      q_r     <= '0;
    end
    if (cmd.div_step) begin
      if (rem_sh >= {1'b0, prod_r}) begin
        rem_d_r <= rem_sh - {1'b0, prod_r};
        q_r     <= {q_r[QUO_W-2:0], 1'b1};
      end else begin
        rem_d_r <= rem_sh;
        q_r     <= {q_r[QUO_W-2:0], 1'b0};
      end
    end
    if (cmd.sqrt_step) begin
      q_r <= q_r << 2;
      if (sq_in >= sq_trial) begin
        sq_rem_r <= (ROOT_W + 2)'(sq_in - sq_trial);
        root_r   <= {root_r[ROOT_W-2:0], 1'b1};
      end else begin
        sq_rem_r <= (ROOT_W + 2)'(sq_in);
        root_r   <= {root_r[ROOT_W-2:0], 1'b0};
      end
    end
    if (cmd.out_load) begin
      cos_r       <= degen_r ? '0 : (clamp_r ? Q_ONE : COS_W'(root_r));
      degen_out_r <= degen_r;
    end
  end

  assign cosine_q16 = cos_r;
  assign degenerate = degen_out_r;

endmodule

// ===== rtl/cosine_similarity_unit.sv =====
// Cosine similarity of two vectors streamed as element pairs. Each accepted
// item carries one pair (elem_a, elem_b); a pair with in_tlast set closes the
// vector and yields one result: the cosine as unsigned Q1.16 (65536 = 1.0,
// truncated) in out_tdata and a degenerate flag in out_tuser, set with a zero
// cosine when either vector has zero magnitude. Accumulators saturate at 44
// bits. Element pairs are taken one per cycle. After the closing pair the
// input stalls while one shared sequencer runs 44-step shift-add multiplies,
// a 32-step restoring divide and a 16-step square root; a pending result does
// not block that work until the next one is ready.
module cosine_similarity_unit #(
  parameter int COUNT_BITS = csu_pkg::COUNT_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [csu_pkg::IN_TDATA_W-1:0]  in_tdata,  // elem_a, elem_b
  input  logic                          in_tlast,  // last_element
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [csu_pkg::OUT_TDATA_W-1:0] out_tdata, // cosine_q16, zero pad
  output logic                          out_tuser  // degenerate
);
  import csu_pkg::*;

  csu_cmd_t          cmd;
  logic [COS_W-1:0]  cos;

  csu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  csu_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .elem_a     (in_tdata[ELEM_W-1:0]),
    .elem_b     (in_tdata[2*ELEM_W-1:ELEM_W]),
    .cosine_q16 (cos),
    .degenerate (out_tuser)
  );

  assign out_tdata = OUT_TDATA_W'(cos);

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[COS_W-1:0] == '0)
    else $error("degenerate result with nonzero cosine");

  a_cos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[COS_W-1:0] <= Q_ONE)
    else $error("cosine above one");

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input not stalled after closing item");

endmodule

// ===== dv/cosine_similarity_unit_checker.sv =====
`timescale 1ns / 1ps

module cosine_similarity_unit_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [csu_pkg::IN_TDATA_W-1:0]   in_tdata,   // elem_a, elem_b
  input  logic                             in_tlast,   // last_element
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [csu_pkg::OUT_TDATA_W-1:0]  out_tdata,  // cosine_q16, zero pad
  input  logic                             out_tuser,  // degenerate
  output int                               pending,
  output int                               fail_count
);
  import csu_pkg::*;

  localparam logic [ACC_W-1:0] ACC_SAT = '1;

  typedef struct packed {
    logic [COS_W-1:0] cosine;
    logic             degenerate;
  } similarity_t;

  logic [ACC_W-1:0] dot_sum, mag_a_sum, mag_b_sum;
  similarity_t      similarity_q[$];

  function automatic logic [ACC_W-1:0] add_sat(logic [ACC_W-1:0] acc, logic [31:0] inc);
    logic [ACC_W:0] s;
    s = {1'b0, acc} + (ACC_W + 1)'(inc);
    return s[ACC_W] ? ACC_SAT : s[ACC_W-1:0];
  endfunction

  // largest q <= 65536 with ma*mb*q^2 <= dot^2 * 2^32
  function automatic logic [COS_W-1:0] cosine_of(logic [ACC_W-1:0] dot,
                                                 logic [ACC_W-1:0] ma,
                                                 logic [ACC_W-1:0] mb);
    logic [127:0] mag_prod, dot_sq, lhs;
    logic [17:0]  lo, hi, mid;
    mag_prod = 128'(ma) * 128'(mb);
    dot_sq   = (128'(dot) * 128'(dot)) << 32;
    lo = 18'd0;
    hi = 18'(Q_ONE);
    while (lo < hi) begin
      mid = (lo + hi + 18'd1) >> 1;
      lhs = mag_prod * (128'(mid) * 128'(mid));
      if (lhs <= dot_sq) lo = mid;
      else hi = mid - 18'd1;
    end
    return lo[COS_W-1:0];
  endfunction

  assign pending = similarity_q.size();

  initial begin
    fail_count = 0;
    dot_sum    = '0;
    mag_a_sum  = '0;
    mag_b_sum  = '0;
  end

  always @(posedge clk) begin
    logic [15:0] ea, eb;
    similarity_t got, want;
    if (!rst_n) begin
      dot_sum   = '0;
      mag_a_sum = '0;
      mag_b_sum = '0;
    end else begin
      if (in_tvalid && in_tready) begin
        ea = in_tdata[15:0];
        eb = in_tdata[31:16];
        dot_sum   = add_sat(dot_sum, 32'(ea) * 32'(eb));
        mag_a_sum = add_sat(mag_a_sum, 32'(ea) * 32'(ea));
        mag_b_sum = add_sat(mag_b_sum, 32'(eb) * 32'(eb));
        if (in_tlast) begin
          if (mag_a_sum == 0 || mag_b_sum == 0) want = '{cosine: '0, degenerate: 1'b1};
          else want = '{cosine: cosine_of(dot_sum, mag_a_sum, mag_b_sum), degenerate: 1'b0};
          similarity_q = {similarity_q, want};
          dot_sum   = '0;
          mag_a_sum = '0;
          mag_b_sum = '0;
        end
      end
      if (out_tvalid && out_tready) begin
        got = '{cosine: out_tdata[COS_W-1:0], degenerate: out_tuser};
        if (similarity_q.size() == 0) begin
          $error("unexpected result item: cosine_q16=%0d degenerate=%0d",
                 got.cosine, got.degenerate);
          fail_count++;
        end else begin
          want = similarity_q.pop_front();
          if (got.cosine !== want.cosine) begin
            $error("cosine_q16 mismatch: expected %0d, actual %0d", want.cosine, got.cosine);
            fail_count++;
          end
          if (got.degenerate !== want.degenerate) begin
            $error("degenerate mismatch: expected %0d, actual %0d",
                   want.degenerate, got.degenerate);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ===== dv/cosine_similarity_unit_test.sv =====
`timescale 1ns / 1ps

module cosine_similarity_unit_test;
  import csu_pkg::*;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_tvalid = 1'b0;
  logic                    in_tready;
  logic [IN_TDATA_W-1:0]   in_tdata = '0;   // elem_a, elem_b
  logic                    in_tlast = 1'b0; // last_element
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  out_tdata;       // cosine_q16, zero pad
  logic                    out_tuser;       // degenerate
  int                      pending, fail_count;
  bit                      send_burst, recv_burst;
  int                      items_sent;

  always #1 clk = ~clk;

  cosine_similarity_unit u_dut (.*);

  cosine_similarity_unit_checker u_checker (.*);

  function automatic int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic logic [15:0] pick_elem();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(1, 15));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_pair(logic [15:0] ea, logic [15:0] eb, logic last_pair);
    int gap;
    if (items_sent % 64 == 0) send_burst = ($urandom_range(0, 3) == 0);
    gap = draw_gap(send_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {eb, ea};
    in_tlast  <= last_pair;
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // result side backpressure
  initial begin
    int gap, results;
    results = 0;
    @(posedge rst_n);
    forever begin
      if (results % 16 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      gap = draw_gap(recv_burst);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      results++;
    end
  end

  initial begin
    int len, drain;
    items_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: single-pair vectors, zero magnitudes, orthogonal, extremes
    send_pair(16'd0, 16'd0, 1'b1);
    send_pair(16'd5, 16'd0, 1'b1);
    send_pair(16'd0, 16'd7, 1'b1);
    send_pair(16'hFFFF, 16'hFFFF, 1'b1);
    send_pair(16'd1, 16'd1, 1'b1);
    send_pair(16'hFFFF, 16'd1, 1'b1);
    send_pair(16'd1, 16'd0, 1'b0);
    send_pair(16'd0, 16'd1, 1'b1);
    send_pair(16'd3, 16'd4, 1'b0);
    send_pair(16'd4, 16'd3, 1'b1);
    send_pair(16'hFFFF, 16'd0, 1'b0);
    send_pair(16'd0, 16'hFFFF, 1'b0);
    send_pair(16'h8000, 16'h7FFF, 1'b1);
    send_pair(16'hAAAA, 16'h5555, 1'b0);
    send_pair(16'h5555, 16'hAAAA, 1'b1);

    // hold off until the block has drained
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);

    while (items_sent < 1700) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 60) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) send_pair(pick_elem(), pick_elem(), i == len - 1);
    end
    in_tvalid <= 1'b0;
    in_tlast  <= 1'b0;

    drain = 0;
    while (pending != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (200) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("cosine_similarity_unit_test passed");
    else $display("cosine_similarity_unit_test failed");
    $finish;
  end

  initial begin
    #10ms;
    $display("cosine_similarity_unit_test failed");
    $finish;
  end

endmodule
